// ===== src/deq_pkg.sv =====
// Shared types and codes of the bounded deque engine.
// Used by the controller, the datapath and the top level.
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_TRAVERSE   = 3'd4,
    OP_REVERSE    = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZDIV  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_TR_RD,
    S_TR_EMIT,
    S_RM_CHK,
    S_RM_RD,
    S_RM_DIV
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    reverse;
    logic    clear;
    logic    rd_en;
    logic    rd_back;
    logic    idx_inc;
    logic    kept_clr;
    logic    kept_inc;
    logic    wr_kept;
    logic    div_start;
    logic    commit_kept;
    logic    set_st;
    status_t st;
    logic    emit;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic zdiv;
    logic idx_last;
    logic idx_done;
    logic div_done;
    logic rem_nz;
    logic out_free;
  } stat_t;

endpackage

// ===== src/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/deq_mod.sv =====
// Bit-serial unsigned remainder unit, one dividend bit per cycle.
// No dependencies.
module deq_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic        rem_nz
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] num;
  logic [31:0] den;
  logic [32:0] rem;
  logic [32:0] trial;

  assign trial  = {rem[31:0], num[31]};
  assign rem_nz = (rem != 33'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        num  <= dividend;
        den  <= divisor;
        rem  <= 33'd0;
      end else if (busy) begin
        // shift in one bit, subtract when it fits
        num <= {num[30:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
        end else begin
          rem <= trial;
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/deq_ctrl.sv =====
// Controller state machine of the deque engine.
// Depends on deq_pkg; drives the datapath through cmd_t, reads stat_t.
module deq_ctrl import deq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.st     = ST_OK;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_st = 1'b1;
        state_next = S_EMIT;
        case (stat.op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (stat.full) begin
              cmd.st = ST_FULL;
            end else begin
              cmd.push_front = (stat.op == OP_PUSH_FRONT);
              cmd.push_back  = (stat.op == OP_PUSH_BACK);
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (stat.empty) begin
              cmd.st = ST_EMPTY;
            end else begin
              cmd.rd_en     = 1'b1;
              cmd.rd_back   = (stat.op == OP_POP_BACK);
              cmd.pop_front = (stat.op == OP_POP_FRONT);
              cmd.pop_back  = (stat.op == OP_POP_BACK);
            end
          end
          OP_TRAVERSE: begin
            if (stat.empty) begin
              cmd.st = ST_EMPTY;
            end else begin
              state_next = S_TR_RD;
            end
          end
          OP_REVERSE: cmd.reverse = 1'b1;
          OP_REMOVE: begin
            if (stat.zdiv) begin
              cmd.st = ST_ZDIV;
            end else begin
              cmd.kept_clr = 1'b1;
              state_next   = S_RM_CHK;
            end
          end
          default: cmd.clear = 1'b1;
        endcase
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TR_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_TR_EMIT;
      end
      S_TR_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = stat.idx_last;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_TR_RD;
          end
        end
      end
      S_RM_CHK: begin
        if (stat.idx_done) begin
          cmd.commit_kept = 1'b1;
          state_next      = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_RM_RD;
        end
      end
      S_RM_RD: begin
        cmd.div_start = 1'b1;
        state_next    = S_RM_DIV;
      end
      S_RM_DIV: begin
        if (stat.div_done) begin
          // keep a word that does not divide evenly
          cmd.wr_kept  = stat.rem_nz;
          cmd.kept_inc = stat.rem_nz;
          cmd.idx_inc  = 1'b1;
          state_next   = S_RM_CHK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/deq_datapath.sv =====
// Datapath of the deque engine: ring store, pointers, remainder unit, output word.
// Depends on deq_pkg, deq_ram and deq_mod.
module deq_datapath import deq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  input  logic signed [31:0] divisor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] element,
  output logic [1:0]         status,
  output logic [5:0]         occupancy,
  output logic               last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          rev;
  logic [CW-1:0] idx;
  logic [CW-1:0] kept;
  op_t           op_q;
  logic [31:0]   val_q;
  logic [31:0]   mag_q;
  status_t       st_q;

  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata, rdata;
  logic          we;
  logic          div_done, rem_nz;
  logic          use_rd;
  logic [CW+5:0] occ_ext;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic back,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    if (back) begin
      s = (CW+1)'(h) + (CW+1)'(DEPTH) - (CW+1)'(off);
    end else begin
      s = (CW+1)'(h) + (CW+1)'(off);
    end
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign raddr = cmd.rd_back ? slot(head, rev, count - CW'(1)) : slot(head, rev, idx);

  always_comb begin
    we    = 1'b0;
    waddr = slot(head, rev, kept);
    wdata = rdata;
    if (cmd.push_front) begin
      we    = 1'b1;
      waddr = slot(head, !rev, CW'(1));
      wdata = val_q;
    end else if (cmd.push_back) begin
      we    = 1'b1;
      waddr = slot(head, rev, count);
      wdata = val_q;
    end else if (cmd.wr_kept) begin
      we = 1'b1;
    end
  end

  deq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  deq_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rdata[31] ? (~rdata + 32'd1) : rdata),
    .divisor  (mag_q),
    .done     (div_done),
    .rem_nz   (rem_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      rev <= 1'b0;
      idx <= '0;
      kept <= '0;
    end else begin
      if (cmd.latch_in) begin
        idx <= '0;
      end
      if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.kept_clr) begin
        kept <= '0;
      end
      if (cmd.kept_inc) begin
        kept <= kept + CW'(1);
      end
      if (cmd.push_front) begin
        head  <= waddr;
        count <= count + CW'(1);
      end
      if (cmd.push_back) begin
        count <= count + CW'(1);
      end
      if (cmd.pop_front) begin
        head  <= slot(head, rev, CW'(1));
        count <= count - CW'(1);
      end
      if (cmd.pop_back) begin
        count <= count - CW'(1);
      end
      if (cmd.reverse) begin
        if (count != '0) begin
          head <= slot(head, rev, count - CW'(1));
        end
        rev <= !rev;
      end
      if (cmd.clear) begin
        head  <= '0;
        count <= '0;
        rev   <= 1'b0;
      end
      if (cmd.commit_kept) begin
        count <= kept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q  <= op_t'(operation);
      val_q <= value;
      mag_q <= divisor[31] ? (~divisor + 32'd1) : divisor;
      st_q  <= ST_OK;
    end
    if (cmd.set_st) begin
      st_q <= cmd.st;
    end
  end

  // output word register
  assign use_rd  = (st_q == ST_OK) &&
                   (op_q inside {OP_POP_FRONT, OP_POP_BACK, OP_TRAVERSE});
  assign occ_ext = {6'd0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      element   <= use_rd ? rdata : 32'd0;
      status    <= st_q;
      occupancy <= occ_ext[5:0];
      last      <= cmd.emit_last;
    end
  end

  always_comb begin
    stat.op       = op_q;
    stat.full     = (count >= CW'(DEPTH));
    stat.empty    = (count == '0);
    stat.zdiv     = (mag_q == 32'd0);
    stat.idx_last = (({1'b0, idx} + (CW+1)'(1)) == {1'b0, count});
    stat.idx_done = (idx == count);
    stat.div_done = div_done;
    stat.rem_nz   = rem_nz;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

// ===== src/bounded_deque_engine_top.sv =====
// Top level of the bounded deque engine.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: operation, value, divisor.
//   Output channel (out_valid/out_ready) returns result words: element, status,
//   occupancy, last. Every operation returns one word with last set, except
//   traverse of a non-empty store, which returns one word per element, in order,
//   with last set on the final one.
//   One operation is in flight at a time; in_ready is high only when idle.
//   After accept, push, pop, reverse and clear pass an execute step and an emit
//   step. Traverse reads and emits each element in turn. Remove of multiples
//   reads each stored element, tests it in the bit-serial remainder unit (32
//   steps) after the registered RAM read, then emits one final word.
//   A new operation is accepted only after the previous one emits its last word.
//   The output register holds a word until out_ready; a stalled receiver holds
//   the engine in its emit step, and no word is lost.
//   Reset clears head, count, direction and the handshake state; store contents
//   are undefined until written and are never read before that.
module bounded_deque_engine_top import deq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  input  logic signed [31:0] divisor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] element,
  output logic [1:0]         status,
  output logic [5:0]         occupancy,
  output logic               last
);

  cmd_t  cmd;
  stat_t stat;

  // sequence each operation
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold store, pointers and result word
  deq_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .value     (value),
    .divisor   (divisor),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .status    (status),
    .occupancy (occupancy),
    .last      (last)
  );

endmodule
